/* hdl/mcsr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mcsr_pkg
// Shared types, codes and limits of the MQTT client session receiver.
// ----------------------------------------------------------------------------
package mcsr_pkg;

    // frame limits
    localparam int MAX_PACKET          = 2048;
    localparam int TOPIC_LIMIT         = 96;
    localparam int OTHER_PAYLOAD_LIMIT = 512;

    // field widths
    localparam int LEN_W   = 28;
    localparam int TOPIC_W = 16;

    // command codes
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // event codes
    localparam logic [2:0] EV_PAYLOAD = 3'd0;
    localparam logic [2:0] EV_ACCEPT  = 3'd1;
    localparam logic [2:0] EV_REFUSE  = 3'd2;
    localparam logic [2:0] EV_CONNECT = 3'd3;
    localparam logic [2:0] EV_PING    = 3'd4;
    localparam logic [2:0] EV_ERROR   = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_RECONNECT = 2'd0;
    localparam logic [1:0] CFG_PING      = 2'd1;
    localparam logic [1:0] CFG_TOPIC     = 2'd2;

    // configuration reset values
    localparam logic [15:0] RECONNECT_RESET = 16'd5000;
    localparam logic [15:0] PING_RESET      = 16'd30000;
    localparam logic [31:0] TOPIC_RESET     = 32'h2F677073;

    // packet types of interest
    localparam logic [3:0] PKT_CONNACK = 4'd2;
    localparam logic [3:0] PKT_PUBLISH = 4'd3;

    typedef struct packed {
        logic [15:0] reconnect_interval;
        logic [15:0] ping_interval;
        logic [31:0] match_topic;
    } t_cfg;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] data_byte;
        logic       route;
        logic       last_byte;
        logic [7:0] ack_flags;
        logic [7:0] return_code;
    } t_result;

endpackage
`default_nettype wire

/* hdl/mqtt_client_session_receiver.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mqtt_client_session_receiver
// MQTT 3.1.1 client receive path: frame decoding plus session timers.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_in_valid / o_in_stall) carries one command per transfer:
//   a received byte, a millisecond tick, or a session start. Output channel
//   (o_out_valid / i_out_stall) carries at most one event per input transfer:
//   payload byte with route and last flag, connack accepted or refused,
//   send connect, send ping, or frame error. Inputs that cause no event give
//   no output transfer.
//   Order: an input taken lands in the input register, and its event is
//   then registered in the result register. Throughput is one transfer per
//   cycle while the output is not stalled; the only loop is the update of the
//   parser and session registers from the input register.
//   While the receiver stalls with an event waiting, one more input is held
//   in the input register, after which o_in_stall rises until the output
//   drains.
//   Reset (synchronous, active low) loads the configuration defaults, puts
//   the parser at the frame header and marks the session not connected.
//   Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at
//   the next edge. The user must make them while the block is idle; unchecked.
// ----------------------------------------------------------------------------
module mqtt_client_session_receiver (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [31:0] i_now_ms,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_event_res,
    output logic [7:0]       o_data_byte,
    output logic             o_route,
    output logic             o_last_byte,
    output logic [7:0]       o_ack_flags,
    output logic [7:0]       o_return_code
);
    import mcsr_pkg::*;

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic [1:0]  r_in_cmd;
    logic [7:0]  r_in_byte;
    logic [31:0] r_in_now;
    logic        r_out_valid;
    t_result     r_out;

    logic        in_accept;
    logic        advance;
    logic        is_byte, is_tick, is_start;
    logic        prs_valid, ses_valid, connack_ok;
    t_result     prs_res, ses_res;
    logic        n_out_valid;
    t_result     n_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reconnect_interval <= RECONNECT_RESET;
            r_cfg.ping_interval      <= PING_RESET;
            r_cfg.match_topic        <= TOPIC_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_RECONNECT) begin
                r_cfg.reconnect_interval <= i_cfg_data[15:0];
            end
            if (i_cfg_index == CFG_PING) begin
                r_cfg.ping_interval <= i_cfg_data[15:0];
            end
            if (i_cfg_index == CFG_TOPIC) begin
                r_cfg.match_topic <= i_cfg_data;
            end
        end
    end

    // handshake control
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_cmd  <= i_cmd;
            r_in_byte <= i_rx_byte;
            r_in_now  <= i_now_ms;
        end
    end

    // command decode for the item being processed
    assign is_byte  = advance && (r_in_cmd == CMD_BYTE);
    assign is_tick  = advance && (r_in_cmd == CMD_TICK);
    assign is_start = advance && (r_in_cmd == CMD_START);

    mcsr_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (is_byte),
        .i_restart     (is_start),
        .i_rx_byte     (r_in_byte),
        .i_match_topic (r_cfg.match_topic),
        .o_res_valid   (prs_valid),
        .o_res         (prs_res),
        .o_connack_ok  (connack_ok)
    );

    mcsr_session u_session (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_tick               (is_tick),
        .i_start              (is_start),
        .i_connack_ok         (connack_ok),
        .i_now_ms             (r_in_now),
        .i_reconnect_interval (r_cfg.reconnect_interval),
        .i_ping_interval      (r_cfg.ping_interval),
        .o_res_valid          (ses_valid),
        .o_res                (ses_res)
    );

    // event select: byte events from the parser, the rest from the session
    always_comb begin
        if (is_byte) begin
            n_out_valid = prs_valid;
            n_out       = prs_res;
        end else begin
            n_out_valid = ses_valid;
            n_out       = ses_res;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_out_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_res   = r_out.event_res;
    assign o_data_byte   = r_out.data_byte;
    assign o_route       = r_out.route;
    assign o_last_byte   = r_out.last_byte;
    assign o_ack_flags   = r_out.ack_flags;
    assign o_return_code = r_out.return_code;

    // a start transfer always answers with a connect request
    a_start_connect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_start |=> (r_out_valid && r_out.event_res == EV_CONNECT))
        else $error("start without connect event");

    // payload-only fields stay clear on other events
    a_payload_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_res != EV_PAYLOAD) |->
        (r_out.data_byte == 8'd0 && !r_out.route && !r_out.last_byte))
        else $error("payload fields set on non-payload event");

    // an accepted connack carries a zero return code
    a_accept_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_res == EV_ACCEPT) |-> (r_out.return_code == 8'd0))
        else $error("accept with nonzero return code");

    // no event code beyond frame error
    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.event_res <= EV_ERROR))
        else $error("event code out of range");

endmodule
`default_nettype wire

/* hdl/mcsr_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mcsr_parser
// Byte-wise MQTT frame decoder: fixed header, remaining length, CONNACK body,
// PUBLISH topic check and payload streaming.
// ----------------------------------------------------------------------------
module mcsr_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_restart,
    input  wire logic [7:0]       i_rx_byte,
    input  wire logic [31:0]      i_match_topic,
    output logic                  o_res_valid,
    output mcsr_pkg::t_result     o_res,
    output logic                  o_connack_ok
);
    import mcsr_pkg::*;

    // parse phases
    localparam logic [2:0] PH_HEADER   = 3'd0;
    localparam logic [2:0] PH_LENGTH   = 3'd1;
    localparam logic [2:0] PH_CONNACK  = 3'd2;
    localparam logic [2:0] PH_TOPIC_HI = 3'd3;
    localparam logic [2:0] PH_TOPIC_LO = 3'd4;
    localparam logic [2:0] PH_TOPIC    = 3'd5;
    localparam logic [2:0] PH_PAYLOAD  = 3'd6;
    localparam logic [2:0] PH_SKIP     = 3'd7;

    localparam logic [LEN_W:0]     MAX_PKT_L   = (LEN_W+1)'(MAX_PACKET);
    localparam logic [TOPIC_W-1:0] TOPIC_LIM_L = TOPIC_W'(TOPIC_LIMIT);
    localparam logic [LEN_W-1:0]   OTHER_LIM_L = LEN_W'(OTHER_PAYLOAD_LIMIT);

    logic [2:0]         r_phase, n_phase;
    logic [3:0]         r_hdr_type, n_hdr_type;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [2:0]         r_seen, n_seen;
    logic [LEN_W-1:0]   r_body, n_body;
    logic [TOPIC_W-1:0] r_tlen, n_tlen;
    logic               r_tm, n_tm;
    logic               r_route, n_route;
    logic               r_pl_en, n_pl_en;
    logic [7:0]         r_first, n_first;

    logic [LEN_W-1:0]   len_part;
    logic [LEN_W-1:0]   len_acc;
    logic [2:0]         seen_inc;
    logic [LEN_W:0]     frame_size;
    logic [LEN_W-1:0]   body_dec;
    logic [LEN_W-1:0]   topic_pos;
    logic [7:0]         topic_ref;
    logic               tm_upd;
    logic [TOPIC_W-1:0] tlen_new;

    // remaining length digit placed at its 7-bit slot
    always_comb begin
        unique case (r_seen[1:0])
            2'd0:    len_part = {21'd0, i_rx_byte[6:0]};
            2'd1:    len_part = {14'd0, i_rx_byte[6:0], 7'd0};
            2'd2:    len_part = {7'd0, i_rx_byte[6:0], 14'd0};
            default: len_part = {i_rx_byte[6:0], 21'd0};
        endcase
    end

    assign len_acc    = r_len | len_part;
    assign seen_inc   = r_seen + 3'd1;
    assign frame_size = {1'b0, len_acc} + (LEN_W+1)'(seen_inc) + (LEN_W+1)'(1);
    assign body_dec   = r_body - LEN_W'(1);
    assign topic_pos  = r_len - LEN_W'(2) - r_body;
    assign tlen_new   = {r_first, i_rx_byte};

    // reference topic byte at the current topic position
    always_comb begin
        unique case (topic_pos[1:0])
            2'd0:    topic_ref = i_match_topic[31:24];
            2'd1:    topic_ref = i_match_topic[23:16];
            2'd2:    topic_ref = i_match_topic[15:8];
            default: topic_ref = i_match_topic[7:0];
        endcase
    end

    assign tm_upd = r_tm && !((topic_pos < LEN_W'(4)) && (topic_ref != i_rx_byte));

    // next state and result for one received byte
    always_comb begin
        n_phase      = r_phase;
        n_hdr_type   = r_hdr_type;
        n_len        = r_len;
        n_seen       = r_seen;
        n_body       = r_body;
        n_tlen       = r_tlen;
        n_tm         = r_tm;
        n_route      = r_route;
        n_pl_en      = r_pl_en;
        n_first      = r_first;
        o_res_valid  = 1'b0;
        o_res        = '0;
        o_connack_ok = 1'b0;

        if (i_en) begin
            unique case (r_phase)
                PH_HEADER: begin
                    n_hdr_type = i_rx_byte[7:4];
                    n_len      = '0;
                    n_seen     = '0;
                    n_phase    = PH_LENGTH;
                end
                PH_LENGTH: begin
                    n_len  = len_acc;
                    n_seen = seen_inc;
                    if (i_rx_byte[7]) begin
                        if (seen_inc >= 3'd4) begin
                            // malformed length: restart at the next byte
                            n_phase           = PH_HEADER;
                            o_res_valid       = 1'b1;
                            o_res.event_res   = EV_ERROR;
                        end
                    end else if (frame_size > MAX_PKT_L) begin
                        // oversized frame: report an error and skip its body
                        n_body          = len_acc;
                        n_phase         = PH_SKIP;
                        o_res_valid     = 1'b1;
                        o_res.event_res = EV_ERROR;
                    end else begin
                        n_body = len_acc;
                        if (len_acc == '0) begin
                            n_phase = PH_HEADER;
                        end else if (r_hdr_type == PKT_CONNACK && len_acc >= LEN_W'(2)) begin
                            n_phase = PH_CONNACK;
                        end else if (r_hdr_type == PKT_PUBLISH && len_acc >= LEN_W'(2)) begin
                            n_phase = PH_TOPIC_HI;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                end
                PH_CONNACK: begin
                    n_body = body_dec;
                    if (r_body == r_len) begin
                        n_first = i_rx_byte;
                    end else begin
                        n_phase           = (body_dec == '0) ? PH_HEADER : PH_SKIP;
                        o_res_valid       = 1'b1;
                        o_res.ack_flags   = r_first;
                        o_res.return_code = i_rx_byte;
                        if (i_rx_byte == 8'd0) begin
                            o_connack_ok    = 1'b1;
                            o_res.event_res = EV_ACCEPT;
                        end else begin
                            o_res.event_res = EV_REFUSE;
                        end
                    end
                end
                PH_TOPIC_HI: begin
                    n_first = i_rx_byte;
                    n_body  = body_dec;
                    n_phase = PH_TOPIC_LO;
                end
                PH_TOPIC_LO: begin
                    n_tlen = tlen_new;
                    n_body = body_dec;
                    if (tlen_new >= TOPIC_LIM_L ||
                        {{(LEN_W-TOPIC_W){1'b0}}, tlen_new} > body_dec) begin
                        n_phase = (body_dec == '0) ? PH_HEADER : PH_SKIP;
                    end else if (tlen_new == '0) begin
                        // empty topic never matches
                        n_tm    = 1'b0;
                        n_route = 1'b1;
                        n_pl_en = body_dec < OTHER_LIM_L;
                        n_phase = (body_dec == '0) ? PH_HEADER : PH_PAYLOAD;
                    end else begin
                        n_tm    = (tlen_new == TOPIC_W'(4));
                        n_phase = PH_TOPIC;
                    end
                end
                PH_TOPIC: begin
                    n_tm   = tm_upd;
                    n_body = body_dec;
                    if ({1'b0, topic_pos} + (LEN_W+1)'(1) >=
                        {{(LEN_W+1-TOPIC_W){1'b0}}, r_tlen}) begin
                        n_route = !tm_upd;
                        n_pl_en = tm_upd || (body_dec < OTHER_LIM_L);
                        n_phase = (body_dec == '0) ? PH_HEADER : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_body = body_dec;
                    if (body_dec == '0) begin
                        n_phase = PH_HEADER;
                    end
                    if (r_pl_en) begin
                        o_res_valid     = 1'b1;
                        o_res.event_res = EV_PAYLOAD;
                        o_res.data_byte = i_rx_byte;
                        o_res.route     = r_route;
                        o_res.last_byte = (body_dec == '0);
                    end
                end
                default: begin
                    // skipped body bytes
                    if (r_body != '0) begin
                        n_body = body_dec;
                        if (body_dec == '0) begin
                            n_phase = PH_HEADER;
                        end
                    end else begin
                        n_phase = PH_HEADER;
                    end
                end
            endcase
        end

        if (i_restart) begin
            n_phase = PH_HEADER;
        end
    end

    // phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
        end else begin
            r_phase <= n_phase;
        end
    end

    // frame bookkeeping, always written before it is read
    always_ff @(posedge i_clk) begin
        r_hdr_type <= n_hdr_type;
        r_len      <= n_len;
        r_seen     <= n_seen;
        r_body     <= n_body;
        r_tlen     <= n_tlen;
        r_tm       <= n_tm;
        r_route    <= n_route;
        r_pl_en    <= n_pl_en;
        r_first    <= n_first;
    end

endmodule
`default_nettype wire

/* hdl/mcsr_session.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mcsr_session
// Connection flag and reconnect / keepalive timers driven by time ticks, session start and accepted connacks.
// ----------------------------------------------------------------------------
module mcsr_session (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_tick,
    input  wire logic             i_start,
    input  wire logic             i_connack_ok,
    input  wire logic [31:0]      i_now_ms,
    input  wire logic [15:0]      i_reconnect_interval,
    input  wire logic [15:0]      i_ping_interval,
    output logic                  o_res_valid,
    output mcsr_pkg::t_result     o_res
);
    import mcsr_pkg::*;

    logic        r_up, n_up;
    logic [31:0] r_last_ping, n_last_ping;
    logic [31:0] r_last_conn, n_last_conn;
    logic [31:0] conn_age;
    logic [31:0] ping_age;

    assign conn_age = i_now_ms - r_last_conn;
    assign ping_age = i_now_ms - r_last_ping;

    // tick, start and connack updates
    always_comb begin
        n_up        = r_up;
        n_last_ping = r_last_ping;
        n_last_conn = r_last_conn;
        o_res_valid = 1'b0;
        o_res       = '0;
        priority if (i_start) begin
            n_up            = 1'b0;
            n_last_ping     = '0;
            n_last_conn     = '0;
            o_res_valid     = 1'b1;
            o_res.event_res = EV_CONNECT;
        end else if (i_connack_ok) begin
            n_up        = 1'b1;
            n_last_ping = '0;
        end else if (i_tick) begin
            if (!r_up && conn_age >= {16'd0, i_reconnect_interval}) begin
                n_last_conn     = i_now_ms;
                o_res_valid     = 1'b1;
                o_res.event_res = EV_CONNECT;
            end else if (r_up && ping_age >= {16'd0, i_ping_interval}) begin
                n_last_ping     = i_now_ms;
                o_res_valid     = 1'b1;
                o_res.event_res = EV_PING;
            end
        end
    end

    // session registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up        <= 1'b0;
            r_last_ping <= '0;
            r_last_conn <= '0;
        end else begin
            r_up        <= n_up;
            r_last_ping <= n_last_ping;
            r_last_conn <= n_last_conn;
        end
    end

endmodule
`default_nettype wire
